[hdl/fdr_pkg.sv]
// Shared constants, row layout and control structs of the LED color fader.
package fdr_pkg;

  localparam int PIXEL_COUNT   = 16;
  localparam int CHANNEL_COUNT = 4;
  localparam int SLOTS         = 4;
  localparam int PIX_W         = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int LVL_W         = 8;
  localparam int SPAN_W        = 24;
  localparam int TIME_W        = 32;
  localparam int IDX_W         = 4;
  localparam int DIV_STEPS     = SPAN_W;
  localparam int CNT_W         = $clog2(DIV_STEPS);
  localparam int TURN_W        = 2;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 24'd1000000;

  // Input command codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SPAN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_RGBW_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_SPAN = 1'd1;

  // One channel of one pixel
  typedef struct packed {
    logic [LVL_W-1:0]  tgt;
    logic [LVL_W-1:0]  cur;
    logic [SPAN_W-1:0] ivl;
    logic [TIME_W-1:0] last;
  } fdr_slot_t;

  // All channels of one pixel, one memory row
  typedef fdr_slot_t [SLOTS-1:0] fdr_row_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load_in;
    logic             div_load;
    logic             div_step;
    logic             set_wr;
    logic             tick_wr;
    logic             turn_adv;
    logic             last;
    logic [PIX_W-1:0] pix;
  } fdr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } fdr_status_t;

endpackage

[hdl/fdr_if.sv]
// Valid/ready channel interfaces for commands and pixel reports.
interface fdr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [fdr_pkg::LVL_W-1:0]   red_in;
  logic [fdr_pkg::LVL_W-1:0]   green_in;
  logic [fdr_pkg::LVL_W-1:0]   blue_in;
  logic [fdr_pkg::TIME_W-1:0]  now_us;

  modport source (output valid, command, red_in, green_in, blue_in, now_us, input ready);
  modport sink   (input valid, command, red_in, green_in, blue_in, now_us, output ready);
endinterface

interface fdr_out_if;
  logic                       valid;
  logic                       ready;
  logic [fdr_pkg::IDX_W-1:0]  pixel_index;
  logic [fdr_pkg::LVL_W-1:0]  red_level;
  logic [fdr_pkg::LVL_W-1:0]  green_level;
  logic [fdr_pkg::LVL_W-1:0]  blue_level;
  logic [fdr_pkg::LVL_W-1:0]  white_level;
  logic                       last_pixel;

  modport source (output valid, pixel_index, red_level, green_level, blue_level, white_level,
                  last_pixel, input ready);
  modport sink   (input valid, pixel_index, red_level, green_level, blue_level, white_level,
                  last_pixel, output ready);
endinterface

[hdl/fdr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

[hdl/fdr_ctrl.sv]
// Sequencer that walks the pixels for set and tick commands.
module fdr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  fdr_pkg::fdr_status_t st,
  output fdr_pkg::fdr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_RD,
    S_SET_LOAD,
    S_SET_DIV,
    S_SET_WR,
    S_TICK_RD,
    S_TICK_WR
  } state_t;

  state_t                          state_r, state_nxt;
  logic [fdr_pkg::PIX_W-1:0]       pix_r, pix_nxt;
  logic [fdr_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            last_pix;

  assign last_pix = (pix_r == fdr_pkg::PIX_W'(fdr_pkg::PIXEL_COUNT - 1));

  // Next state and command decode
  always_comb begin
    state_nxt    = state_r;
    pix_nxt      = pix_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.pix      = pix_r;
    cmd.last     = last_pix;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pix_nxt     = '0;
          state_nxt   = (in_command == fdr_pkg::CMD_TICK) ? S_TICK_RD : S_SET_RD;
        end
      end
      S_SET_RD: begin
        state_nxt = S_SET_LOAD;
      end
      S_SET_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_SET_DIV;
      end
      S_SET_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == fdr_pkg::CNT_W'(fdr_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_SET_WR;
        end else begin
          cnt_nxt = cnt_r + fdr_pkg::CNT_W'(1);
        end
      end
      S_SET_WR: begin
        cmd.set_wr = 1'b1;
        if (last_pix) begin
          state_nxt = S_IDLE;
        end else begin
          pix_nxt   = pix_r + fdr_pkg::PIX_W'(1);
          state_nxt = S_SET_RD;
        end
      end
      S_TICK_RD: begin
        state_nxt = S_TICK_WR;
      end
      S_TICK_WR: begin
        // hold until the output register can take the report
        if (st.out_free) begin
          cmd.tick_wr = 1'b1;
          if (last_pix) begin
            cmd.turn_adv = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            pix_nxt   = pix_r + fdr_pkg::PIX_W'(1);
            state_nxt = S_TICK_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pix_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pix_r   <= pix_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[hdl/fdr_dp.sv]
// Datapath: pixel state memory, interval dividers, fade step and report register.
module fdr_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fdr_pkg::fdr_cmd_t                 cmd,
  output fdr_pkg::fdr_status_t              st,
  input  logic                              cfg_we,
  input  logic [fdr_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [fdr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [fdr_pkg::LVL_W-1:0]         in_red,
  input  logic [fdr_pkg::LVL_W-1:0]         in_green,
  input  logic [fdr_pkg::LVL_W-1:0]         in_blue,
  input  logic [fdr_pkg::TIME_W-1:0]        in_now,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fdr_pkg::IDX_W-1:0]         out_pixel_index,
  output logic [fdr_pkg::LVL_W-1:0]         out_red,
  output logic [fdr_pkg::LVL_W-1:0]         out_green,
  output logic [fdr_pkg::LVL_W-1:0]         out_blue,
  output logic [fdr_pkg::LVL_W-1:0]         out_white,
  output logic                              out_last
);

  localparam int LW = fdr_pkg::LVL_W;
  localparam int SW = fdr_pkg::SPAN_W;
  localparam int TW = fdr_pkg::TIME_W;
  localparam int NS = fdr_pkg::SLOTS;

  // Configuration and latched command payload
  logic                        rgbw_r;
  logic [SW-1:0]               span_r;
  logic [LW-1:0]               red_r, green_r, blue_r;
  logic [TW-1:0]               now_r;
  logic [fdr_pkg::TURN_W-1:0]  turn_r;

  // Memory access
  logic [fdr_pkg::PIXEL_COUNT-1:0] row_vld_r;
  logic                            rd_vld_r;
  logic [$bits(fdr_pkg::fdr_row_t)-1:0] rd_raw;
  fdr_pkg::fdr_row_t               row_rd, row_set, row_tick, row_wr;

  // Divider lanes, quotient shifts in from the bottom of dvd_r
  logic [SW-1:0] dvd_r  [NS];
  logic [LW-1:0] rem_r  [NS];
  logic [LW-1:0] dist_r [NS];
  logic [LW:0]   rem_sh [NS];
  logic          q_bit  [NS];
  logic [LW-1:0] rem_nxt[NS];
  logic [LW-1:0] dist_c [NS];
  logic [SW-1:0] ivl_c  [NS];
  logic [LW-1:0] tgt_new[NS];
  logic [LW-1:0] min_rgb;

  // Tick step of the served channel
  fdr_pkg::fdr_slot_t slot_old, slot_upd;
  logic [TW-1:0]      elapsed;

  // Report register
  logic                          out_valid_r;
  logic [fdr_pkg::IDX_W-1:0]     out_pix_r;
  logic [LW-1:0]                 out_red_r, out_green_r, out_blue_r, out_white_r;
  logic                          out_last_r;
  logic [fdr_pkg::PIX_W+fdr_pkg::IDX_W-1:0] pix_ext;

  fdr_ram #(
    .WIDTH ($bits(fdr_pkg::fdr_row_t)),
    .DEPTH (fdr_pkg::PIXEL_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.set_wr | cmd.tick_wr),
    .wr_addr (cmd.pix),
    .wr_data (row_wr),
    .rd_addr (cmd.pix),
    .rd_data (rd_raw)
  );

  // Rows never written read as zero
  assign row_rd = rd_vld_r ? fdr_pkg::fdr_row_t'(rd_raw) : '0;

  // New targets, with white taken out in RGBW mode
  always_comb begin
    min_rgb = red_r;
    if (green_r < min_rgb) min_rgb = green_r;
    if (blue_r < min_rgb)  min_rgb = blue_r;
    if (rgbw_r) begin
      tgt_new[0] = red_r - min_rgb;
      tgt_new[1] = green_r - min_rgb;
      tgt_new[2] = blue_r - min_rgb;
      tgt_new[3] = min_rgb;
    end else begin
      tgt_new[0] = red_r;
      tgt_new[1] = green_r;
      tgt_new[2] = blue_r;
      tgt_new[3] = row_rd[3].tgt;
    end
  end

  // Distances, divider step and final interval for each lane
  always_comb begin
    for (int c = 0; c < NS; c++) begin
      dist_c[c]  = (tgt_new[c] >= row_rd[c].cur) ? (tgt_new[c] - row_rd[c].cur)
                                                  : (row_rd[c].cur - tgt_new[c]);
      rem_sh[c]  = {rem_r[c], dvd_r[c][SW-1]};
      q_bit[c]   = (rem_sh[c] >= {1'b0, dist_r[c]});
      rem_nxt[c] = q_bit[c] ? LW'(rem_sh[c] - {1'b0, dist_r[c]}) : rem_sh[c][LW-1:0];
      if (dist_r[c] == '0 || span_r == '0) begin
        ivl_c[c] = '0;
      end else if (dvd_r[c] == '0) begin
        ivl_c[c] = SW'(1);
      end else begin
        ivl_c[c] = dvd_r[c];
      end
    end
  end

  // Row written back by a set
  always_comb begin
    row_set = row_rd;
    for (int c = 0; c < NS; c++) begin
      row_set[c].tgt = tgt_new[c];
      if (c < fdr_pkg::CHANNEL_COUNT) begin
        row_set[c].ivl = ivl_c[c];
      end
    end
  end

  // Row written back by a tick: step or snap the served channel
  always_comb begin
    slot_old = row_rd[turn_r];
    slot_upd = slot_old;
    elapsed  = now_r - slot_old.last;
    if (slot_old.ivl != '0) begin
      if (slot_old.cur != slot_old.tgt && elapsed >= {{(TW-SW){1'b0}}, slot_old.ivl}) begin
        slot_upd.last = now_r;
        slot_upd.cur  = (slot_old.cur < slot_old.tgt) ? slot_old.cur + LW'(1)
                                                      : slot_old.cur - LW'(1);
      end
    end else begin
      slot_upd.cur = slot_old.tgt;
    end
    row_tick         = row_rd;
    row_tick[turn_r] = slot_upd;
  end

  assign row_wr  = cmd.set_wr ? row_set : row_tick;
  assign pix_ext = {{fdr_pkg::IDX_W{1'b0}}, cmd.pix};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rgbw_r <= 1'b0;
      span_r <= fdr_pkg::SPAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fdr_pkg::CFG_RGBW_MODE: rgbw_r <= cfg_data[0];
        fdr_pkg::CFG_FADE_SPAN: span_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the accepted command payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      now_r   <= in_now;
    end
  end

  // Row valid bits and channel rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      turn_r    <= '0;
    end else begin
      rd_vld_r <= row_vld_r[cmd.pix];
      if (cmd.set_wr || cmd.tick_wr) begin
        row_vld_r[cmd.pix] <= 1'b1;
      end
      if (cmd.turn_adv) begin
        turn_r <= (turn_r == fdr_pkg::TURN_W'(fdr_pkg::CHANNEL_COUNT - 1))
                  ? '0 : turn_r + fdr_pkg::TURN_W'(1);
      end
    end
  end

  // Advance the divider lanes one quotient bit per cycle
  always_ff @(posedge clk) begin
    for (int c = 0; c < NS; c++) begin
      if (cmd.div_load) begin
        dvd_r[c]  <= span_r;
        rem_r[c]  <= '0;
        dist_r[c] <= dist_c[c];
      end else if (cmd.div_step) begin
        dvd_r[c] <= {dvd_r[c][SW-2:0], q_bit[c]};
        rem_r[c] <= rem_nxt[c];
      end
    end
  end

  // Report register: load on a tick write, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.tick_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_wr) begin
      out_pix_r   <= pix_ext[fdr_pkg::IDX_W-1:0];
      out_red_r   <= row_tick[0].cur;
      out_green_r <= row_tick[1].cur;
      out_blue_r  <= row_tick[2].cur;
      out_white_r <= row_tick[3].cur;
      out_last_r  <= cmd.last;
    end
  end

  assign st.out_free      = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_pixel_index  = out_pix_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;
  assign out_white        = out_white_r;
  assign out_last         = out_last_r;

endmodule

[hdl/rgbw_led_color_fader.sv]
// Top level of the RGBW LED color fader.
//
// in_if takes commands: command 0 sets a common red/green/blue target for all
// pixels (white is split off as min(r,g,b) when rgbw_mode is 1), command 1 is
// a time tick carrying now_us. A set produces no report; a tick steps one
// channel (rotating red, green, blue, white) of every pixel and then sends one
// report per pixel on out_if, pixel 0 first, last_pixel high on the final one.
// The user writes rgbw_mode (index 0) and fade_span_us (index 1) only while idle.
//
// One item is handled at a time; in_if.ready is high only while idle.
// A set walks each pixel through a row read, a load, a bit-serial divide of the
// span by each channel's distance (four lanes in parallel) and a write back.
// A tick walks each pixel through a row read and a step with write back, plus
// any stall time; the first report is registered at the step of pixel 0.
// The block does not enforce the idle rule for writes on the cfg port.
// The report register lets the next pixel be read while a report waits; when
// out_if.ready is low the walk holds at the next pixel until the slot frees.
// Reset clears the controller, the channel rotation and the row valid bits,
// so all pixel state reads as zero; no clearing pass is needed.
module rgbw_led_color_fader (
  input  logic                               clk,
  input  logic                               rst_n,
  fdr_in_if.sink                             in_if,
  fdr_out_if.source                          out_if,
  input  logic                               cfg_we,
  input  logic [fdr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [fdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  fdr_pkg::fdr_cmd_t    cmd;
  fdr_pkg::fdr_status_t st;

  fdr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .in_ready   (in_if.ready),
    .st         (st),
    .cmd        (cmd)
  );

  fdr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .in_red          (in_if.red_in),
    .in_green        (in_if.green_in),
    .in_blue         (in_if.blue_in),
    .in_now          (in_if.now_us),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_pixel_index (out_if.pixel_index),
    .out_red         (out_if.red_level),
    .out_green       (out_if.green_level),
    .out_blue        (out_if.blue_level),
    .out_white       (out_if.white_level),
    .out_last        (out_if.last_pixel)
  );

  // A report is never loaded over one that has not been transferred
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_wr |-> st.out_free)
    else $error("report loaded while output register is occupied");

  // The controller issues at most one datapath operation per cycle
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.div_load, cmd.div_step, cmd.set_wr, cmd.tick_wr}))
    else $error("conflicting datapath commands");

  // Rotation advances only with the final pixel of a tick
  a_turn_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.turn_adv |-> (cmd.tick_wr && cmd.last))
    else $error("channel rotation advanced outside the last tick write");

  // A new command is not taken right after one is transferred
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input ready right after a command transfer");

endmodule
